// ===== rtl/core/mssrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mssrt_pkg
// Shared types and constants of the multi-slot sound repeat timer.
// ----------------------------------------------------------------------------
package mssrt_pkg;

    localparam int CODE_W   = 16;
    localparam int TIMER_W  = 16;
    localparam int LEFT_W   = 14;
    localparam int HANDLE_W = 2;
    localparam int BUSY_W   = 4;
    localparam int ANSWER_W = 5;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_DELAYED = 2'd0,
        MODE_MSTART  = 2'd1,
        MODE_MEASURE = 2'd2,
        MODE_REPEAT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TICK_END = 3'd0,
        KIND_FIRE     = 3'd1,
        KIND_EFFECT   = 3'd2,
        KIND_ANSWER   = 3'd3,
        KIND_STOP_ACK = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_UPD,
        ST_TICK_END,
        ST_PLAY_FIRE,
        ST_PLAY_ANS,
        ST_STOP_ACK
    } state_t;

    typedef struct packed {
        mode_t                mode;
        logic [CODE_W-1:0]    code;
        logic [TIMER_W-1:0]   timer;
        logic [TIMER_W-1:0]   gap;
        logic [LEFT_W-1:0]    left;
        logic [HANDLE_W-1:0]  handle;
    } entry_t;

    typedef struct packed {
        entry_t               nxt;
        logic                 fire;
        kind_t                kind;
        logic                 release_slot;
    } upd_t;

    // zero or negative in 16-bit two's complement
    function automatic logic not_positive(input logic [TIMER_W-1:0] v);
        return (v == '0) || v[TIMER_W-1];
    endfunction

endpackage

// ===== rtl/core/mssrt_ram.sv =====
// ----------------------------------------------------------------------------
// mssrt_ram
// Slot entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mssrt_ram
    import mssrt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mssrt_slot_upd.sv =====
// ----------------------------------------------------------------------------
// mssrt_slot_upd
// One tick of one slot: new entry contents and the fire it causes.
// ----------------------------------------------------------------------------
module mssrt_slot_upd
    import mssrt_pkg::*;
#(
    parameter int HANDLE_COUNT = 4
)
(
    input  entry_t            cur,
    input  logic [BUSY_W-1:0] busy,
    output upd_t              upd
);

    logic [TIMER_W-1:0]  tdec;
    logic [TIMER_W-1:0]  ginc;
    logic                tfire;
    logic [LEFT_W-1:0]   left_dec;
    logic                left_done;
    logic [HANDLE_W-1:0] pick;
    logic                pick_found;

    assign tdec  = cur.timer - TIMER_W'(1);
    assign ginc  = cur.gap + TIMER_W'(1);
    assign tfire = not_positive(tdec);

    always_comb
    begin
        left_dec  = cur.left;
        left_done = 1'b0;
        if (cur.left != '0)
        begin
            left_dec  = cur.left - LEFT_W'(1);
            left_done = (left_dec == '0);
        end
    end

    // lowest idle handle, handle 0 when all are busy
    always_comb
    begin
        pick       = '0;
        pick_found = 1'b0;
        for (int h = 0; h < HANDLE_COUNT; h++)
        begin
            if (!pick_found && !busy[h])
            begin
                pick       = HANDLE_W'(h);
                pick_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        upd              = '0;
        upd.nxt          = cur;
        upd.kind         = KIND_FIRE;
        case (cur.mode)
            MODE_DELAYED:
            begin
                upd.nxt.timer    = tdec;
                upd.fire         = tfire;
                upd.release_slot = tfire;
            end
            MODE_MSTART:
            begin
                upd.nxt.timer = tdec;
                if (tfire)
                begin
                    upd.fire       = 1'b1;
                    upd.kind       = KIND_EFFECT;
                    upd.nxt.handle = pick;
                    upd.nxt.gap    = '0;
                    upd.nxt.mode   = MODE_MEASURE;
                    upd.nxt.left   = left_dec;
                end
            end
            MODE_MEASURE:
            begin
                upd.nxt.gap = ginc;
                if (!busy[cur.handle])
                begin
                    upd.fire         = 1'b1;
                    upd.nxt.timer    = ginc;
                    upd.nxt.mode     = MODE_REPEAT;
                    upd.nxt.left     = left_dec;
                    upd.release_slot = left_done;
                end
            end
            default:
            begin
                upd.nxt.timer = tdec;
                if (tfire)
                begin
                    upd.fire         = 1'b1;
                    upd.nxt.timer    = cur.gap;
                    upd.nxt.left     = left_dec;
                    upd.release_slot = left_done;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/multi_slot_sound_repeat_timer.sv =====
// ----------------------------------------------------------------------------
// multi_slot_sound_repeat_timer
// Slot scheduler for delayed, fixed-repeat and measured-repeat sound fires.
// ----------------------------------------------------------------------------
// One item is handled at a time. A stop passes through the stop-ack state
// and a play through the answer state, with the fire state before it when
// the play fires at once. A tick walks every slot in ascending order: a free
// slot is only skipped in the read state, an occupied slot is read from the
// slot store and then updated and written back, and the tick-end state then
// loads the tick end. The slot store has a single read port with registered
// read data. Busy flags live in flip-flops and clear at reset; the slot
// store needs no clearing pass. Results leave through one output register,
// which is refilled in the same cycle as the previous result transfers.
// ----------------------------------------------------------------------------
module multi_slot_sound_repeat_timer
    import mssrt_pkg::*;
#(
    parameter int SLOT_COUNT   = 16,
    parameter int HANDLE_COUNT = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [CODE_W-1:0]          sound_code,
    input  logic signed [TIMER_W-1:0]  start_delay,
    input  logic signed [TIMER_W-1:0]  repeat_gap,
    input  logic [LEFT_W-1:0]          repeat_count,
    input  logic signed [ANSWER_W-1:0] stop_slot,
    input  logic [BUSY_W-1:0]          busy_handles,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 kind,
    output logic [CODE_W-1:0]          fired_code,
    output logic [HANDLE_W-1:0]        effect_handle,
    output logic signed [ANSWER_W-1:0] slot_answer,
    output logic                       last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SLOT_COUNT-1:0] busy_reg, busy_next;
    logic [BUSY_W-1:0]    hbusy_reg, hbusy_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [ANSWER_W-1:0]  ans_reg, ans_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                kind_reg, kind_next;
    logic [CODE_W-1:0]    fcode_reg, fcode_next;
    logic [HANDLE_W-1:0]  fhandle_reg, fhandle_next;
    logic [ANSWER_W-1:0]  sans_reg, sans_next;
    logic                 last_reg, last_next;

    logic                 in_xfer;
    logic                 out_free;
    logic                 idx_last;

    // play request decode
    logic [TIMER_W-1:0]   gap_eff;
    logic                 play_now;
    logic [IDX_W-1:0]     free_idx;
    logic                 free_found;
    logic                 stop_ok;
    logic [IDX_W-1:0]     stop_idx;

    // slot store ports
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic                 rd_en;
    entry_t               rd_data;
    upd_t                 upd;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign idx_last = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    // a single fire turns into a plain delayed fire
    assign gap_eff  = (repeat_count == LEFT_W'(1)) ? '0 : repeat_gap;
    assign play_now = not_positive(start_delay) && (gap_eff == '0);

    assign stop_ok  = !stop_slot[ANSWER_W-1] &&
                      (int'(stop_slot[ANSWER_W-2:0]) < SLOT_COUNT);
    assign stop_idx = IDX_W'(stop_slot[ANSWER_W-2:0]);

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (!busy_reg[s])
            begin
                free_idx   = IDX_W'(s);
                free_found = 1'b1;
            end
        end
    end

    mssrt_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    mssrt_slot_upd #(
        .HANDLE_COUNT (HANDLE_COUNT)
    ) u_upd (
        .cur  (rd_data),
        .busy (hbusy_reg),
        .upd  (upd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (op)
                        OP_TICK: state_next = ST_TICK_RD;
                        OP_PLAY: state_next = play_now ? ST_PLAY_FIRE : ST_PLAY_ANS;
                        OP_STOP: state_next = ST_STOP_ACK;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_RD:
            begin
                if (busy_reg[idx_reg])
                begin
                    state_next = ST_TICK_UPD;
                end
                else if (idx_last)
                begin
                    state_next = ST_TICK_END;
                end
            end
            ST_TICK_UPD:
            begin
                if (!upd.fire || out_free)
                begin
                    state_next = idx_last ? ST_TICK_END : ST_TICK_RD;
                end
            end
            ST_PLAY_FIRE:
            begin
                if (out_free)
                begin
                    state_next = ST_PLAY_ANS;
                end
            end
            ST_TICK_END, ST_PLAY_ANS, ST_STOP_ACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result loading
    always_comb
    begin
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        hbusy_next     = hbusy_reg;
        code_next      = code_reg;
        ans_next       = ans_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        fcode_next     = fcode_reg;
        fhandle_next   = fhandle_reg;
        sans_next      = sans_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = upd.nxt;
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next   = '0;
                    hbusy_next = busy_handles;
                    code_next  = sound_code;
                    ans_next   = '1;
                    if (op == OP_PLAY && !play_now && free_found)
                    begin
                        // claim the slot and write its entry
                        busy_next[free_idx] = 1'b1;
                        ans_next       = ANSWER_W'(free_idx);
                        wr_en          = 1'b1;
                        wr_addr        = free_idx;
                        wr_data.code   = sound_code;
                        wr_data.timer  = start_delay;
                        wr_data.gap    = gap_eff;
                        wr_data.left   = repeat_count;
                        if (gap_eff == '0)
                        begin
                            wr_data.mode = MODE_DELAYED;
                        end
                        else if (gap_eff[TIMER_W-1])
                        begin
                            wr_data.mode = MODE_MSTART;
                        end
                        else
                        begin
                            wr_data.mode = MODE_REPEAT;
                        end
                    end
                    if (op == OP_STOP && stop_ok)
                    begin
                        busy_next[stop_idx] = 1'b0;
                    end
                end
            end
            ST_TICK_RD:
            begin
                if (busy_reg[idx_reg])
                begin
                    rd_en = 1'b1;
                end
                else if (!idx_last)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TICK_UPD:
            begin
                if (!upd.fire || out_free)
                begin
                    wr_en = 1'b1;
                    if (upd.release_slot)
                    begin
                        busy_next[idx_reg] = 1'b0;
                    end
                    if (upd.fire)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = upd.kind;
                        fcode_next     = rd_data.code;
                        fhandle_next   = (upd.kind == KIND_EFFECT) ? upd.nxt.handle : '0;
                        sans_next      = '0;
                        last_next      = 1'b0;
                    end
                    if (!idx_last)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_TICK_END, ST_STOP_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = (state_reg == ST_TICK_END) ? KIND_TICK_END
                                                                : KIND_STOP_ACK;
                    fcode_next     = '0;
                    fhandle_next   = '0;
                    sans_next      = '0;
                    last_next      = 1'b1;
                end
            end
            ST_PLAY_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_FIRE;
                    fcode_next     = code_reg;
                    fhandle_next   = '0;
                    sans_next      = '0;
                    last_next      = 1'b0;
                end
            end
            ST_PLAY_ANS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ANSWER;
                    fcode_next     = '0;
                    fhandle_next   = '0;
                    sans_next      = ans_reg;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hbusy_reg   <= hbusy_next;
        code_reg    <= code_next;
        ans_reg     <= ans_next;
        kind_reg    <= kind_next;
        fcode_reg   <= fcode_next;
        fhandle_reg <= fhandle_next;
        sans_reg    <= sans_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign fired_code    = fcode_reg;
    assign effect_handle = fhandle_reg;
    assign slot_answer   = sans_reg;
    assign last          = last_reg;

endmodule

// ===== sim/multi_slot_sound_repeat_timer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_sound_repeat_timer_checker
// Watches both channels, predicts the timer's results and compares them.
// ----------------------------------------------------------------------------
module multi_slot_sound_repeat_timer_checker
    import mssrt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [CODE_W-1:0]          sound_code,
    input  logic signed [TIMER_W-1:0]  start_delay,
    input  logic signed [TIMER_W-1:0]  repeat_gap,
    input  logic [LEFT_W-1:0]          repeat_count,
    input  logic signed [ANSWER_W-1:0] stop_slot,
    input  logic [BUSY_W-1:0]          busy_handles,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [2:0]                 kind,
    input  logic [CODE_W-1:0]          fired_code,
    input  logic [HANDLE_W-1:0]        effect_handle,
    input  logic signed [ANSWER_W-1:0] slot_answer,
    input  logic                       last,
    output int                         fail_count,
    output int                         pending,
    output int                         fires_seen
);

    localparam int SLOTS   = 16;
    localparam int HANDLES = 4;

    typedef struct packed {
        logic [2:0]          kind;
        logic [CODE_W-1:0]   code;
        logic [HANDLE_W-1:0] handle;
        logic [ANSWER_W-1:0] answer;
        logic                last;
    } event_t;

    event_t expected_events[$];

    logic                busy_q   [SLOTS];
    mode_t               mode_q   [SLOTS];
    logic [CODE_W-1:0]   code_q   [SLOTS];
    logic [TIMER_W-1:0]  timer_q  [SLOTS];
    logic [TIMER_W-1:0]  gap_q    [SLOTS];
    logic [LEFT_W-1:0]   left_q   [SLOTS];
    logic [HANDLE_W-1:0] handle_q [SLOTS];

    function automatic bit is_nonpos(logic [15:0] v);
        return v == 16'd0 || v[15];
    endfunction

    function automatic bit use_fire(int s);
        if (left_q[s] != 0) begin
            left_q[s] = left_q[s] - 1'b1;
            return left_q[s] == 0;
        end
        return 0;
    endfunction

    task automatic push_event(logic [2:0] k, logic [15:0] c, logic [1:0] h,
                              logic [4:0] a);
        event_t e;
        e.kind = k; e.code = c; e.handle = h; e.answer = a; e.last = 1'b0;
        expected_events.push_back(e);
    endtask

    task automatic schedule_item(logic [1:0] o, logic [15:0] c, logic [15:0] d,
                                 logic [15:0] g, logic [13:0] n, logic [4:0] st,
                                 logic [3:0] bz);
        int found;
        int h;
        event_t e;
        found = -1;
        case (o)
            OP_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!busy_q[s]) continue;
                    case (mode_q[s])
                        MODE_DELAYED: begin
                            timer_q[s] = timer_q[s] - 1'b1;
                            if (is_nonpos(timer_q[s])) begin
                                push_event(KIND_FIRE, code_q[s], 0, 0);
                                busy_q[s] = 0;
                            end
                        end
                        MODE_MSTART: begin
                            timer_q[s] = timer_q[s] - 1'b1;
                            if (is_nonpos(timer_q[s])) begin
                                h = 0;
                                for (int i = HANDLES - 1; i >= 0; i--)
                                    if (!bz[i]) h = i;
                                handle_q[s] = h[1:0];
                                push_event(KIND_EFFECT, code_q[s], handle_q[s], 0);
                                gap_q[s]  = 0;
                                mode_q[s] = MODE_MEASURE;
                                void'(use_fire(s));
                            end
                        end
                        MODE_MEASURE: begin
                            gap_q[s] = gap_q[s] + 1'b1;
                            if (!bz[handle_q[s]]) begin
                                push_event(KIND_FIRE, code_q[s], 0, 0);
                                timer_q[s] = gap_q[s];
                                mode_q[s]  = MODE_REPEAT;
                                if (use_fire(s)) busy_q[s] = 0;
                            end
                        end
                        default: begin
                            timer_q[s] = timer_q[s] - 1'b1;
                            if (is_nonpos(timer_q[s])) begin
                                push_event(KIND_FIRE, code_q[s], 0, 0);
                                timer_q[s] = gap_q[s];
                                if (use_fire(s)) busy_q[s] = 0;
                            end
                        end
                    endcase
                end
                push_event(KIND_TICK_END, 0, 0, 0);
            end
            OP_PLAY: begin
                if (n == 14'd1) g = 0;
                if (is_nonpos(d) && g == 0) begin
                    push_event(KIND_FIRE, c, 0, 0);
                end else begin
                    for (int s = SLOTS - 1; s >= 0; s--)
                        if (!busy_q[s]) found = s;
                    if (found >= 0) begin
                        busy_q[found]  = 1;
                        timer_q[found] = d;
                        code_q[found]  = c;
                        if (g == 0) mode_q[found] = MODE_DELAYED;
                        else if (g[15]) begin
                            left_q[found] = n;
                            mode_q[found] = MODE_MSTART;
                        end else begin
                            gap_q[found]  = g;
                            left_q[found] = n;
                            mode_q[found] = MODE_REPEAT;
                        end
                    end
                end
                push_event(KIND_ANSWER, 0, 0, found[4:0]);
            end
            OP_STOP: begin
                if (!st[4]) busy_q[st[3:0]] = 0;
                push_event(KIND_STOP_ACK, 0, 0, 0);
            end
            default: return;
        endcase
        e = expected_events.pop_back();
        e.last = 1'b1;
        expected_events.push_back(e);
    endtask

    assign pending = expected_events.size();

    always @(posedge clk or negedge rst_n) begin
        event_t e;
        if (!rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                busy_q[s] = 0; mode_q[s] = MODE_DELAYED;
            end
            fail_count = 0;
            fires_seen = 0;
        end else begin
            // check the result first: a play cannot answer in its own cycle
            if (out_valid && !out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result kind %0d", kind);
                    fail_count++;
                end else begin
                    e = expected_events.pop_front();
                    if (kind != e.kind) begin
                        $error("kind: expected %0d actual %0d", e.kind, kind);
                        fail_count++;
                    end
                    if (fired_code != e.code) begin
                        $error("fired_code: expected %0h actual %0h", e.code, fired_code);
                        fail_count++;
                    end
                    if (effect_handle != e.handle) begin
                        $error("effect_handle: expected %0d actual %0d",
                               e.handle, effect_handle);
                        fail_count++;
                    end
                    if (slot_answer != e.answer) begin
                        $error("slot_answer: expected %0d actual %0d",
                               $signed(e.answer), slot_answer);
                        fail_count++;
                    end
                    if (last != e.last) begin
                        $error("last: expected %0d actual %0d", e.last, last);
                        fail_count++;
                    end
                    if (kind == KIND_FIRE || kind == KIND_EFFECT) fires_seen++;
                end
            end
            if (in_valid && !in_stall)
                schedule_item(op, sound_code, start_delay, repeat_gap,
                              repeat_count, stop_slot, busy_handles);
        end
    end

endmodule

// ===== sim/multi_slot_sound_repeat_timer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_sound_repeat_timer_tb
// Directed and random play, stop and tick traffic with varied back-pressure.
// ----------------------------------------------------------------------------
module multi_slot_sound_repeat_timer_tb;
    import mssrt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [15:0] sound_code;
    logic signed [15:0] start_delay;
    logic signed [15:0] repeat_gap;
    logic [13:0] repeat_count;
    logic signed [4:0]  stop_slot;
    logic [3:0]  busy_handles;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [15:0] fired_code;
    logic [1:0]  effect_handle;
    logic signed [4:0]  slot_answer;
    logic        last;

    int fail_count;
    int pending;
    int fires_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int phase;
    int items_sent;

    multi_slot_sound_repeat_timer dut (.*);

    multi_slot_sound_repeat_timer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall, plus one long hold-off at the start of the
    // stall phase, counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles <= 0;
        end
        else if (phase == 2 && hold_cycles < 300)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one item; hold it stable until the transfer, then advance.
    task automatic send_item(logic [1:0] o, logic [15:0] c, logic [15:0] d,
                             logic [15:0] g, logic [13:0] n, logic [4:0] st,
                             logic [3:0] bz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        sound_code   <= c;
        start_delay  <= d;
        repeat_gap   <= g;
        repeat_count <= n;
        stop_slot    <= st;
        busy_handles <= bz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Mostly small timers so slots actually fire; a few full-range values.
    task automatic send_random;
        logic [15:0] d;
        logic [15:0] g;
        logic [13:0] n;
        int pick;
        pick = $urandom_range(99);
        d = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)) - 16'd1;
        case ($urandom_range(3))
            0: g = 16'd0;
            1: g = 16'($urandom_range(4));
            2: g = -16'sd1;
            default: g = 16'($urandom);
        endcase
        n = ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(4));
        if (pick < 55)
            send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                      14'($urandom), 5'($urandom), 4'($urandom));
        else if (pick < 85)
            send_item(OP_PLAY, 16'($urandom), d, g, n, 5'($urandom), 4'($urandom));
        else if (pick < 97)
            send_item(OP_STOP, 16'($urandom), 16'($urandom), 16'($urandom),
                      14'($urandom), 5'($urandom_range(31)), 4'($urandom));
        else
            send_item(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                      14'($urandom), 5'($urandom), 4'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_TICK;
        sound_code = '0;
        start_delay = '0;
        repeat_gap = '0;
        repeat_count = '0;
        stop_slot = '0;
        busy_handles = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        phase = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: immediate fire, each mode, extremes, stop corner cases.
        send_item(OP_PLAY, 16'hFFFF, 16'sh8000, 16'd0, 14'd0, 5'd0, 4'd0);
        send_item(OP_PLAY, 16'h0000, 16'd0, 16'd5, 14'd1, 5'd0, 4'd0);
        send_item(OP_PLAY, 16'h1111, 16'd2, 16'd0, 14'd0, 5'd0, 4'd0);
        send_item(OP_PLAY, 16'h2222, 16'd1, 16'd2, 14'd3, 5'd0, 4'd0);
        send_item(OP_PLAY, 16'h3333, 16'd1, 16'sh8000, 14'd0, 5'd0, 4'd0);
        send_item(OP_PLAY, 16'h4444, 16'sh7FFF, 16'sh7FFF, 14'h3FFF, 5'd0, 4'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 14'd0, 5'd0, 4'hF);
        send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 14'd0, 5'd0, 4'hF);
        send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 14'd0, 5'd0, 4'hE);
        send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 14'd0, 5'd0, 4'h0);
        send_item(OP_STOP, 16'd0, 16'd0, 16'd0, 14'd0, 5'h1F, 4'd0);
        send_item(OP_STOP, 16'd0, 16'd0, 16'd0, 14'd0, 5'd15, 4'd0);
        send_item(OP_STOP, 16'd0, 16'd0, 16'd0, 14'd0, 5'h10, 4'd0);
        send_item(OP_NONE, 16'd0, 16'd0, 16'd0, 14'd0, 5'd0, 4'd0);
        // fill every free slot, then the plays that find none must answer -1
        for (int i = 0; i < 17; i++)
            send_item(OP_PLAY, 16'(i), 16'sh7FFF, 16'd0, 14'd0, 5'd0, 4'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 14'd0, 5'd0, 4'd0);
        for (int i = 0; i < 16; i++)
            send_item(OP_STOP, 16'd0, 16'd0, 16'd0, 14'd0, 5'(i), 4'd0);

        // Random phases: none, sender idle, receiver stall, both.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1) ? 58 : (p == 3) ? 23 : 0;
            recv_stall_pct = (p == 2) ? 58 : (p == 3) ? 23 : 0;
            phase = p;
            for (int i = 0; i < 28; i++) send_random();
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d items, %0d fire results checked, under four stall mixes",
                 items_sent, fires_seen);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mssrt_pkg.sv
rtl/core/mssrt_ram.sv
rtl/core/mssrt_slot_upd.sv
rtl/core/multi_slot_sound_repeat_timer.sv
sim/multi_slot_sound_repeat_timer_checker.sv
sim/multi_slot_sound_repeat_timer_tb.sv
